// ===== rtl/pvt_pkg.sv =====
// pvt_pkg: shared types, register indexes and helpers of the velocity PID thrust block.
// No dependencies; imported by pid_velocity_thrust.
package pvt_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int VEL_W    = 32;   // velocity, gain and tick fields
    localparam int THRUST_W = 8;
    localparam int CLAMP_W  = 2;
    localparam int REG_IDX_W = 3;
    localparam int CFG_W    = 32;
    localparam int ACC_W    = 64;
    localparam int ALU_W    = 66;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TARGET   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OUT_MIN  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OUT_MAX  = 3'd5;

    // clamp codes
    localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
    localparam logic [CLAMP_W-1:0] CLAMP_MAX  = 2'd1;
    localparam logic [CLAMP_W-1:0] CLAMP_MIN  = 2'd2;

    // reset values: target is minus three in Q16.16
    localparam logic [VEL_W-1:0]    TARGET_RESET  = 32'hFFFD_0000;
    localparam logic [THRUST_W-1:0] OUT_MIN_RESET = 8'd0;
    localparam logic [THRUST_W-1:0] OUT_MAX_RESET = 8'd100;

    localparam logic [ACC_W-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [VEL_W-1:0] measured_velocity;
        logic [VEL_W-1:0]        tick_ms;
    } pvt_in_t;

    typedef struct packed {
        logic [THRUST_W-1:0] thrust;
        logic [CLAMP_W-1:0]  clamp_state;
    } pvt_out_t;

    // clamp a wide sum to the symmetric 64-bit range
    function automatic logic [ACC_W-1:0] sat64(input logic [ALU_W-1:0] y);
        logic signed [ALU_W-1:0] hi;
        logic signed [ALU_W-1:0] lo;
        hi = {{(ALU_W-ACC_W){1'b0}}, POS_MAX};
        lo = ~hi + {{(ALU_W-1){1'b0}}, 1'b1};
        if ($signed(y) > hi)
            return POS_MAX;
        else if ($signed(y) < lo)
            return ~POS_MAX + {{(ACC_W-1){1'b0}}, 1'b1};
        else
            return y[ACC_W-1:0];
    endfunction

    function automatic logic [ACC_W-1:0] apply_sign(input logic [ACC_W-1:0] m, input logic n);
        return n ? (~m + {{(ACC_W-1){1'b0}}, 1'b1}) : m;
    endfunction

endpackage

// ===== rtl/pid_velocity_thrust.sv =====
// pid_velocity_thrust: velocity PID controller with clamped integer thrust output.
// Depends on pvt_pkg (payload structs, register indexes, saturation helpers).
//
// Usage
//   Input channel (in_valid / in_stall / in_data) carries one request: measured velocity
//   and millisecond tick. Output channel (out_valid / out_stall / out_data) returns one
//   result per request: thrust and clamp state.
//   Config port (cfg_wen / cfg_index / cfg_data) writes gains, target and clamp limits;
//   write only while the block is idle. Unknown indexes are ignored.
// Timing
//   Sums, differences, products and the divide run through one 66-bit adder under a small
//   sequencer. The four products are shift-add, one multiplier bit per cycle; the
//   derivative divide is restoring, one quotient bit per cycle. The next request can be
//   accepted in the same cycle as out_valid rises. in_stall is high from acceptance until
//   the result is registered; one request at a time.
// Stall
//   The result sits in an output register. A new request can be accepted while it waits;
//   the sequencer holds its finished result until the output register is free.
// Reset
//   Asynchronous, active low. Config returns to its defaults (target minus three,
//   limits 0..100), integral, last error and last tick clear, no result is pending.
module pid_velocity_thrust
    import pvt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pvt_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pvt_out_t             out_data,
    input  logic                 cfg_wen,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int EW     = DATA_WIDTH;
    localparam int CNT_W  = 6;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(VEL_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ACC_W - 1);
    // error saturates to +/-(2^(EW-1)-1)
    localparam logic [ALU_W-1:0] ERR_LIM   = ({{(ALU_W-1){1'b0}}, 1'b1} << (EW - 1))
                                             - {{(ALU_W-1){1'b0}}, 1'b1};
    localparam logic [ALU_W-1:0] ERR_LIM_N = ~ERR_LIM + {{(ALU_W-1){1'b0}}, 1'b1};

    // sequencer states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ERR     = 4'd1;
    localparam logic [3:0] ST_DT      = 4'd2;
    localparam logic [3:0] ST_DIFF    = 4'd3;
    localparam logic [3:0] ST_MUL     = 4'd4;
    localparam logic [3:0] ST_MFIN    = 4'd5;
    localparam logic [3:0] ST_DIV     = 4'd6;
    localparam logic [3:0] ST_DFIN    = 4'd7;
    localparam logic [3:0] ST_ADD_INT = 4'd8;
    localparam logic [3:0] ST_ADD_PD  = 4'd9;
    localparam logic [3:0] ST_ADD_OUT = 4'd10;
    localparam logic [3:0] ST_CLAMP   = 4'd11;

    // which product the multiplier is working on
    localparam logic [1:0] OP_P   = 2'd0;
    localparam logic [1:0] OP_I   = 2'd1;
    localparam logic [1:0] OP_INC = 2'd2;
    localparam logic [1:0] OP_D   = 2'd3;

    // config
    logic [VEL_W-1:0]    gain_p_reg, gain_i_reg, gain_d_reg, target_reg;
    logic [THRUST_W-1:0] out_min_reg, out_max_reg;

    // control and loop state
    logic [3:0]          state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [ACC_W-1:0]    integ_reg, integ_next;
    logic [EW-1:0]       last_error_reg, last_error_next;
    logic [VEL_W-1:0]    last_tick_reg, last_tick_next;

    // datapath
    logic [VEL_W-1:0]    meas_reg, meas_next;
    logic [VEL_W-1:0]    tick_reg, tick_next;
    logic [EW-1:0]       err_reg, err_next;
    logic [EW:0]         diff_reg, diff_next;
    logic [VEL_W-1:0]    dt_reg, dt_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                ovf_reg, ovf_next;
    logic [VEL_W-1:0]    mplier_reg, mplier_next;
    logic [ACC_W-1:0]    mcand_reg, mcand_next;
    logic                neg_reg, neg_next;
    logic [VEL_W-1:0]    rem_reg, rem_next;
    logic [ACC_W-1:0]    prop_reg, prop_next;
    logic [ACC_W-1:0]    inc_reg, inc_next;
    logic [ACC_W-1:0]    deriv_reg, deriv_next;
    logic [ACC_W-1:0]    sum_reg, sum_next;
    pvt_out_t            out_reg, out_next;

    // shared adder
    logic [ALU_W-1:0]    alu_a, alu_b, alu_y;
    logic                alu_sub;

    logic [VEL_W-1:0]    mag_gp, mag_gi, mag_gd;
    logic [EW-1:0]       mag_err;
    logic [EW:0]         mag_diff;
    logic                prod_sat;
    logic [ACC_W-1:0]    qmag, imag, qdiv, max_q, min_q;
    logic [VEL_W:0]      div_shift;

    assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(ALU_W-1){1'b0}}, alu_sub};

    assign mag_gp   = gain_p_reg[VEL_W-1] ? (~gain_p_reg + VEL_W'(1)) : gain_p_reg;
    assign mag_gi   = gain_i_reg[VEL_W-1] ? (~gain_i_reg + VEL_W'(1)) : gain_i_reg;
    assign mag_gd   = gain_d_reg[VEL_W-1] ? (~gain_d_reg + VEL_W'(1)) : gain_d_reg;
    assign mag_err  = err_reg[EW-1] ? (~err_reg + EW'(1)) : err_reg;
    assign mag_diff = diff_reg[EW] ? (~diff_reg + (EW+1)'(1)) : diff_reg;

    // product result: all-ones counts as saturated too
    assign prod_sat = ovf_reg | (&acc_reg);
    assign qmag     = prod_sat ? POS_MAX : (acc_reg >> FRAC_BITS);
    assign imag     = (prod_sat | acc_reg[ACC_W-1]) ? POS_MAX : acc_reg;
    assign qdiv     = acc_reg >> FRAC_BITS;
    assign div_shift = {rem_reg, acc_reg[ACC_W-1]};

    assign max_q = {{(ACC_W-THRUST_W-FRAC_BITS){1'b0}}, out_max_reg, {FRAC_BITS{1'b0}}};
    assign min_q = {{(ACC_W-THRUST_W-FRAC_BITS){1'b0}}, out_min_reg, {FRAC_BITS{1'b0}}};

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        integ_next      = integ_reg;
        last_error_next = last_error_reg;
        last_tick_next  = last_tick_reg;
        meas_next       = meas_reg;
        tick_next       = tick_reg;
        err_next        = err_reg;
        diff_next       = diff_reg;
        dt_next         = dt_reg;
        acc_next        = acc_reg;
        ovf_next        = ovf_reg;
        mplier_next     = mplier_reg;
        mcand_next      = mcand_reg;
        neg_next        = neg_reg;
        rem_next        = rem_reg;
        prop_next       = prop_reg;
        inc_next        = inc_reg;
        deriv_next      = deriv_reg;
        sum_next        = sum_reg;
        out_next        = out_reg;
        alu_a           = '0;
        alu_b           = '0;
        alu_sub         = 1'b0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    meas_next  = in_data.measured_velocity;
                    tick_next  = in_data.tick_ms;
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                alu_a   = {{(ALU_W-VEL_W){target_reg[VEL_W-1]}}, target_reg};
                alu_b   = {{(ALU_W-VEL_W){meas_reg[VEL_W-1]}}, meas_reg};
                alu_sub = 1'b1;
                if ($signed(alu_y) > $signed(ERR_LIM))
                    err_next = ERR_LIM[EW-1:0];
                else if ($signed(alu_y) < $signed(ERR_LIM_N))
                    err_next = ERR_LIM_N[EW-1:0];
                else
                    err_next = alu_y[EW-1:0];
                state_next = ST_DT;
            end
            ST_DT:
            begin
                alu_a          = {{(ALU_W-VEL_W){1'b0}}, tick_reg};
                alu_b          = {{(ALU_W-VEL_W){1'b0}}, last_tick_reg};
                alu_sub        = 1'b1;
                dt_next        = alu_y[VEL_W-1:0];
                last_tick_next = tick_reg;
                state_next     = ST_DIFF;
            end
            ST_DIFF:
            begin
                alu_a           = {{(ALU_W-EW){err_reg[EW-1]}}, err_reg};
                alu_b           = {{(ALU_W-EW){last_error_reg[EW-1]}}, last_error_reg};
                alu_sub         = 1'b1;
                diff_next       = alu_y[EW:0];
                last_error_next = err_reg;
                // proportional product first
                mplier_next = mag_gp;
                mcand_next  = {{(ACC_W-EW){1'b0}}, mag_err};
                neg_next    = gain_p_reg[VEL_W-1] ^ err_reg[EW-1];
                acc_next    = '0;
                ovf_next    = 1'b0;
                cnt_next    = MUL_LAST;
                op_next     = OP_P;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                // MSB-first shift-add; overflow is sticky
                alu_a       = {1'b0, acc_reg, 1'b0};
                alu_b       = mplier_reg[VEL_W-1] ? {2'b00, mcand_reg} : '0;
                acc_next    = alu_y[ACC_W-1:0];
                ovf_next    = ovf_reg | acc_reg[ACC_W-1] | alu_y[ACC_W];
                mplier_next = mplier_reg << 1;
                cnt_next    = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_MFIN;
            end
            ST_MFIN:
            begin
                case (op_reg)
                    OP_P:
                    begin
                        prop_next = apply_sign(qmag, neg_reg);
                        if (dt_reg == '0)
                        begin
                            inc_next   = '0;
                            deriv_next = '0;
                            state_next = ST_ADD_INT;
                        end
                        else
                        begin
                            mplier_next = mag_gi;
                            mcand_next  = {{(ACC_W-EW){1'b0}}, mag_err};
                            neg_next    = gain_i_reg[VEL_W-1] ^ err_reg[EW-1];
                            acc_next    = '0;
                            ovf_next    = 1'b0;
                            cnt_next    = MUL_LAST;
                            op_next     = OP_I;
                            state_next  = ST_MUL;
                        end
                    end
                    OP_I:
                    begin
                        // Ki*e times dt, sign carried over
                        mplier_next = dt_reg;
                        mcand_next  = qmag;
                        acc_next    = '0;
                        ovf_next    = 1'b0;
                        cnt_next    = MUL_LAST;
                        op_next     = OP_INC;
                        state_next  = ST_MUL;
                    end
                    OP_INC:
                    begin
                        inc_next    = apply_sign(imag, neg_reg);
                        mplier_next = mag_gd;
                        mcand_next  = {{(ACC_W-EW-1){1'b0}}, mag_diff};
                        neg_next    = gain_d_reg[VEL_W-1] ^ diff_reg[EW];
                        acc_next    = '0;
                        ovf_next    = 1'b0;
                        cnt_next    = MUL_LAST;
                        op_next     = OP_D;
                        state_next  = ST_MUL;
                    end
                    OP_D:
                    begin
                        if (prod_sat)
                        begin
                            deriv_next = apply_sign(POS_MAX, neg_reg);
                            state_next = ST_ADD_INT;
                        end
                        else
                        begin
                            // acc holds the dividend and collects the quotient
                            rem_next   = '0;
                            cnt_next   = DIV_LAST;
                            state_next = ST_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV:
            begin
                alu_a   = {{(ALU_W-VEL_W-1){1'b0}}, div_shift};
                alu_b   = {{(ALU_W-VEL_W){1'b0}}, dt_reg};
                alu_sub = 1'b1;
                if (!alu_y[ALU_W-1])
                    rem_next = alu_y[VEL_W-1:0];
                else
                    rem_next = div_shift[VEL_W-1:0];
                acc_next = {acc_reg[ACC_W-2:0], ~alu_y[ALU_W-1]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_DFIN;
            end
            ST_DFIN:
            begin
                deriv_next = apply_sign(qdiv, neg_reg);
                state_next = ST_ADD_INT;
            end
            ST_ADD_INT:
            begin
                alu_a      = {{(ALU_W-ACC_W){integ_reg[ACC_W-1]}}, integ_reg};
                alu_b      = {{(ALU_W-ACC_W){inc_reg[ACC_W-1]}}, inc_reg};
                integ_next = sat64(alu_y);
                state_next = ST_ADD_PD;
            end
            ST_ADD_PD:
            begin
                alu_a      = {{(ALU_W-ACC_W){prop_reg[ACC_W-1]}}, prop_reg};
                alu_b      = {{(ALU_W-ACC_W){deriv_reg[ACC_W-1]}}, deriv_reg};
                sum_next   = sat64(alu_y);
                state_next = ST_ADD_OUT;
            end
            ST_ADD_OUT:
            begin
                alu_a      = {{(ALU_W-ACC_W){sum_reg[ACC_W-1]}}, sum_reg};
                alu_b      = {{(ALU_W-ACC_W){integ_reg[ACC_W-1]}}, integ_reg};
                sum_next   = sat64(alu_y);
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                // wait here while the previous result is still held
                if (!out_valid_reg || !out_stall)
                begin
                    if ($signed(sum_reg) > $signed(max_q))
                    begin
                        out_next.thrust      = out_max_reg;
                        out_next.clamp_state = CLAMP_MAX;
                    end
                    else if ($signed(sum_reg) < $signed(min_q))
                    begin
                        out_next.thrust      = out_min_reg;
                        out_next.clamp_state = CLAMP_MIN;
                    end
                    else
                    begin
                        out_next.thrust      = sum_reg[FRAC_BITS +: THRUST_W];
                        out_next.clamp_state = CLAMP_NONE;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control, loop state and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_P;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            integ_reg      <= '0;
            last_error_reg <= '0;
            last_tick_reg  <= '0;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            target_reg     <= TARGET_RESET;
            out_min_reg    <= OUT_MIN_RESET;
            out_max_reg    <= OUT_MAX_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            integ_reg      <= integ_next;
            last_error_reg <= last_error_next;
            last_tick_reg  <= last_tick_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_GAIN_P:  gain_p_reg  <= cfg_data;
                    REG_GAIN_I:  gain_i_reg  <= cfg_data;
                    REG_GAIN_D:  gain_d_reg  <= cfg_data;
                    REG_TARGET:  target_reg  <= cfg_data;
                    REG_OUT_MIN: out_min_reg <= cfg_data[THRUST_W-1:0];
                    REG_OUT_MAX: out_max_reg <= cfg_data[THRUST_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        meas_reg   <= meas_next;
        tick_reg   <= tick_next;
        err_reg    <= err_next;
        diff_reg   <= diff_next;
        dt_reg     <= dt_next;
        acc_reg    <= acc_next;
        ovf_reg    <= ovf_next;
        mplier_reg <= mplier_next;
        mcand_reg  <= mcand_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        prop_reg   <= prop_next;
        inc_reg    <= inc_next;
        deriv_reg  <= deriv_next;
        sum_reg    <= sum_next;
        out_reg    <= out_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
